/* hw/rtl/sync_length_header_deframer_core_defines.svh */
// assertion macros for the sync/length-header deframer
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef SYNC_LENGTH_HEADER_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_LENGTH_HEADER_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// next-cycle implication
`define SLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define SLD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/sld_pkg.sv */
// types and constants of the sync/length-header deframer
// no dependencies
package sld_pkg;

  // frame layout
  localparam int unsigned HEADER_BYTES = 20;
  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam int unsigned POS_W        = 5;

  localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] SESSION_LO  = POS_W'(4);
  localparam logic [POS_W-1:0] SESSION_HI  = POS_W'(7);
  localparam logic [POS_W-1:0] MSG_ID_LO   = POS_W'(14);
  localparam logic [POS_W-1:0] MSG_ID_HI   = POS_W'(15);
  localparam logic [POS_W-1:0] LENGTH_LO   = POS_W'(16);
  localparam logic [POS_W-1:0] LENGTH_HI   = POS_W'(19);

  // framing phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

endpackage

/* hw/rtl/sync_length_header_deframer_core.sv */
// a payload beat or empty-packet marker appears in the cycle after the byte is taken
// throughput: one byte per cycle; the only stall comes from a full, stalled output register
// the framing state machine and the result register are updated in the same cycle
// reset: synchronous, active-low rst_n; returns to hunting with all header fields zero
// depends on sld_pkg and sync_length_header_deframer_core_defines.svh
`include "sync_length_header_deframer_core_defines.svh"

module sync_length_header_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_present,
  output logic        out_before_nul,
  output logic [15:0] out_msg_id,
  output logic [31:0] out_session_word,
  output logic        out_last
);

  sld_pkg::phase_t                 phase_r, phase_nxt;
  logic [sld_pkg::POS_W-1:0]       header_pos_r, header_pos_nxt;
  logic [31:0]                     held_session_r, held_session_nxt;
  logic [15:0]                     held_msg_id_r, held_msg_id_nxt;
  logic [31:0]                     bytes_left_r, bytes_left_nxt;
  logic                            nul_seen_r, nul_seen_nxt;

  logic                            out_valid_r;
  logic [7:0]                      out_payload_byte_r, res_byte;
  logic                            out_byte_present_r, res_present;
  logic                            out_before_nul_r, res_before;
  logic [15:0]                     out_msg_id_r;
  logic [31:0]                     out_session_word_r;
  logic                            out_last_r, res_last;
  logic                            res_valid;

  logic                            in_acc;
  logic [7:0]                      b;
  logic [sld_pkg::POS_W-1:0]       pos;
  logic [31:0]                     dec;

  // input side only waits when the result register is full and held
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign b        = in_rx_byte;
  assign pos      = header_pos_r;
  assign dec      = bytes_left_r - 32'd1;

  // framing next state and result
  always_comb begin
    phase_nxt        = phase_r;
    header_pos_nxt   = header_pos_r;
    held_session_nxt = held_session_r;
    held_msg_id_nxt  = held_msg_id_r;
    bytes_left_nxt   = bytes_left_r;
    nul_seen_nxt     = nul_seen_r;
    res_valid        = 1'b0;
    res_byte         = 8'd0;
    res_present      = 1'b0;
    res_before       = 1'b0;
    res_last         = 1'b0;
    if (in_acc) begin
      unique case (phase_r)
        sld_pkg::PH_HEAD: begin
          // capture the little-endian header fields by lane
          if (pos >= sld_pkg::SESSION_LO && pos <= sld_pkg::SESSION_HI) begin
            held_session_nxt = held_session_r | ({24'd0, b} << {pos[1:0], 3'b000});
          end else if (pos >= sld_pkg::MSG_ID_LO && pos <= sld_pkg::MSG_ID_HI) begin
            held_msg_id_nxt = held_msg_id_r | ({8'd0, b} << {pos[0], 3'b000});
          end else if (pos >= sld_pkg::LENGTH_LO && pos <= sld_pkg::LENGTH_HI) begin
            bytes_left_nxt = bytes_left_r | ({24'd0, b} << {pos[1:0], 3'b000});
          end
          if (pos >= sld_pkg::POS_LAST) begin
            header_pos_nxt = '0;
            if (bytes_left_nxt == 32'd0) begin
              // empty packet marker
              phase_nxt = sld_pkg::PH_HUNT;
              res_valid = 1'b1;
              res_last  = 1'b1;
            end else begin
              phase_nxt    = sld_pkg::PH_BODY;
              nul_seen_nxt = 1'b0;
            end
          end else begin
            header_pos_nxt = pos + sld_pkg::POS_W'(1);
          end
        end
        sld_pkg::PH_BODY: begin
          // forward one payload beat
          res_valid      = 1'b1;
          res_byte       = b;
          res_present    = 1'b1;
          res_before     = !nul_seen_r && (b != 8'd0);
          res_last       = (dec == 32'd0);
          bytes_left_nxt = dec;
          if (b == 8'd0) begin
            nul_seen_nxt = 1'b1;
          end
          if (dec == 32'd0) begin
            phase_nxt = sld_pkg::PH_HUNT;
          end
        end
        default: begin
          // hunting, also the unused phase code
          if (b == sld_pkg::SYNC_BYTE) begin
            phase_nxt        = sld_pkg::PH_HEAD;
            header_pos_nxt   = sld_pkg::POS_FIRST;
            held_session_nxt = 32'd0;
            held_msg_id_nxt  = 16'd0;
            bytes_left_nxt   = 32'd0;
            nul_seen_nxt     = 1'b0;
          end else begin
            phase_nxt = sld_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sld_pkg::PH_HUNT;
      header_pos_r   <= '0;
      held_session_r <= 32'd0;
      held_msg_id_r  <= 16'd0;
      bytes_left_r   <= 32'd0;
      nul_seen_r     <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_pos_r   <= header_pos_nxt;
      held_session_r <= held_session_nxt;
      held_msg_id_r  <= held_msg_id_nxt;
      bytes_left_r   <= bytes_left_nxt;
      nul_seen_r     <= nul_seen_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_payload_byte_r <= res_byte;
      out_byte_present_r <= res_present;
      out_before_nul_r   <= res_before;
      out_msg_id_r       <= held_msg_id_nxt;
      out_session_word_r <= held_session_nxt;
      out_last_r         <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_byte_r;
  assign out_byte_present = out_byte_present_r;
  assign out_before_nul   = out_before_nul_r;
  assign out_msg_id       = out_msg_id_r;
  assign out_session_word = out_session_word_r;
  assign out_last         = out_last_r;

  // checks
  `SLD_ASSERT_NXT(a_body_beat_out, clk, rst_n,
                  in_acc && phase_r == sld_pkg::PH_BODY, out_valid_r)
  `SLD_ASSERT_IMP(a_body_len_nonzero, clk, rst_n,
                  phase_r == sld_pkg::PH_BODY, bytes_left_r != 32'd0)
  `SLD_ASSERT_IMP(a_head_pos_range, clk, rst_n, phase_r == sld_pkg::PH_HEAD,
                  header_pos_r >= sld_pkg::POS_FIRST && header_pos_r <= sld_pkg::POS_LAST)
  `SLD_ASSERT_IMP(a_marker_shape, clk, rst_n, out_valid_r && !out_byte_present_r,
                  out_last_r && out_payload_byte_r == 8'd0 && !out_before_nul_r)

endmodule
